### sv/wtc_pkg.sv
package wtc_pkg;

  // Word buffer: long enough for the longest fixed word, longer words never match
  localparam int BUF_DEPTH = 15;
  localparam int LEN_W     = 5;
  localparam logic [LEN_W-1:0] LEN_LONG = LEN_W'(BUF_DEPTH + 1);
  localparam int TEXT_W    = BUF_DEPTH * 8;
  localparam int NUM_FIXED = 51;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [5:0] {
    CLS_IDENT = 6'd0,
    CLS_ADD,
    CLS_END,
    CLS_INT,
    CLS_MULT,
    CLS_REAL,
    CLS_RELOP,
    CLS_OR,
    CLS_AND,
    CLS_NOT,
    CLS_EQ,
    CLS_SEMI,
    CLS_COMMA,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_ASSIGN,
    CLS_IF,
    CLS_WHILE,
    CLS_RETURN,
    CLS_ELSE,
    CLS_STRING,
    CLS_TYPE,
    CLS_WSPACE,
    CLS_G_LISTA_VAR,
    CLS_G_PROGRAMA,
    CLS_G_DEFINICIONES,
    CLS_G_DEFINICION,
    CLS_G_DEF_VAR,
    CLS_G_DEF_FUNC,
    CLS_G_PARAMETROS,
    CLS_G_LISTA_PARAM,
    CLS_G_BLOQ_FUNC,
    CLS_G_DEF_LOCALES,
    CLS_G_DEF_LOCAL,
    CLS_G_SENTENCIAS,
    CLS_G_SENTENCIA,
    CLS_G_OTRO,
    CLS_G_BLOQUE,
    CLS_G_VALOR_REGRESA,
    CLS_G_ARGUMENTOS,
    CLS_G_LISTA_ARGUMENTOS,
    CLS_G_TERMINO,
    CLS_G_LLAMADA_FUNC,
    CLS_G_SENTENCIA_BLOQUE,
    CLS_G_EXPRESION
  } cls_t;

  typedef struct packed {
    logic all_int;
    logic all_real;
    logic saw_quote;
  } word_flags_t;

  localparam word_flags_t FLAGS_CLEAR = '{all_int: 1'b1, all_real: 1'b1, saw_quote: 1'b0};

  typedef struct packed {
    cls_t cls;
    logic run_last;
  } result_t;

  // Fixed word: text right-aligned, first character in the highest used byte
  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [3:0]        len;
    cls_t              cls;
  } fixed_word_t;

  localparam fixed_word_t FIXED_WORDS [NUM_FIXED] = '{
    '{"+", 4'd1, CLS_ADD},      '{"-", 4'd1, CLS_ADD},
    '{"*", 4'd1, CLS_MULT},     '{"/", 4'd1, CLS_MULT},
    '{"<", 4'd1, CLS_RELOP},    '{"<=", 4'd2, CLS_RELOP},
    '{">", 4'd1, CLS_RELOP},    '{">=", 4'd2, CLS_RELOP},
    '{"||", 4'd2, CLS_OR},      '{"&&", 4'd2, CLS_AND},
    '{"!", 4'd1, CLS_NOT},      '{"!=", 4'd2, CLS_EQ},
    '{"==", 4'd2, CLS_EQ},      '{";", 4'd1, CLS_SEMI},
    '{",", 4'd1, CLS_COMMA},    '{"(", 4'd1, CLS_LPAREN},
    '{")", 4'd1, CLS_RPAREN},   '{"{", 4'd1, CLS_LBRACE},
    '{"}", 4'd1, CLS_RBRACE},   '{"=", 4'd1, CLS_ASSIGN},
    '{"if", 4'd2, CLS_IF},      '{"while", 4'd5, CLS_WHILE},
    '{"return", 4'd6, CLS_RETURN},
    '{"else", 4'd4, CLS_ELSE},  '{"int", 4'd3, CLS_TYPE},
    '{"float", 4'd5, CLS_TYPE}, '{"void", 4'd4, CLS_TYPE},
    '{"char", 4'd4, CLS_TYPE},  '{"\t", 4'd1, CLS_WSPACE},
    '{"ListaVar", 4'd8, CLS_G_LISTA_VAR},
    '{"programa", 4'd8, CLS_G_PROGRAMA},
    '{"Definiciones", 4'd12, CLS_G_DEFINICIONES},
    '{"Definicion", 4'd10, CLS_G_DEFINICION},
    '{"DefVar", 4'd6, CLS_G_DEF_VAR},
    '{"DefFunc", 4'd7, CLS_G_DEF_FUNC},
    '{"Parametros", 4'd10, CLS_G_PARAMETROS},
    '{"ListaParam", 4'd10, CLS_G_LISTA_PARAM},
    '{"BloqFunc", 4'd8, CLS_G_BLOQ_FUNC},
    '{"DefLocales", 4'd10, CLS_G_DEF_LOCALES},
    '{"DefLocal", 4'd8, CLS_G_DEF_LOCAL},
    '{"Sentencias", 4'd10, CLS_G_SENTENCIAS},
    '{"Sentencia", 4'd9, CLS_G_SENTENCIA},
    '{"Otro", 4'd4, CLS_G_OTRO},
    '{"Bloque", 4'd6, CLS_G_BLOQUE},
    '{"ValorRegresa", 4'd12, CLS_G_VALOR_REGRESA},
    '{"Argumentos", 4'd10, CLS_G_ARGUMENTOS},
    '{"ListaArgumentos", 4'd15, CLS_G_LISTA_ARGUMENTOS},
    '{"Termino", 4'd7, CLS_G_TERMINO},
    '{"LlamadaFunc", 4'd11, CLS_G_LLAMADA_FUNC},
    '{"SentenciaBloque", 4'd15, CLS_G_SENTENCIA_BLOQUE},
    '{"Expresion", 4'd9, CLS_G_EXPRESION}
  };

  // Character i (0 = first) of fixed word k
  function automatic logic [7:0] fixed_char(int k, int i);
    fixed_word_t w;
    int          pos;
    w   = FIXED_WORDS[k];
    pos = int'(w.len) - 1 - i;
    if (pos < 0) begin
      pos = 0;
    end
    return w.text[pos*8 +: 8];
  endfunction

endpackage

### sv/wtc_chan_if.sv
interface wtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       src_last;

  modport source (output valid, output ch, output src_last, input ready);
  modport sink   (input valid, input ch, input src_last, output ready);
endinterface

interface wtc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] token_class;
  logic       run_last;

  modport source (output valid, output token_class, output run_last, input ready);
  modport sink   (input valid, input token_class, input run_last, output ready);
endinterface

### sv/wtc_classify.sv
module wtc_classify (
  input  logic [7:0]                 word_buf [wtc_pkg::BUF_DEPTH],
  input  logic [wtc_pkg::LEN_W-1:0]  word_len,
  input  wtc_pkg::word_flags_t       flags,
  output wtc_pkg::cls_t              word_cls
);
  import wtc_pkg::*;

  logic [NUM_FIXED-1:0] hit;

  // Compare the word against every fixed word in parallel
  always_comb begin
    for (int k = 0; k < NUM_FIXED; k++) begin
      hit[k] = (word_len == LEN_W'(FIXED_WORDS[k].len));
      for (int i = 0; i < BUF_DEPTH; i++) begin
        if ((i < int'(FIXED_WORDS[k].len)) && (word_buf[i] != fixed_char(k, i))) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // Fixed word wins, lowest table entry first; otherwise character flags decide
  always_comb begin
    if (flags.all_int) begin
      word_cls = CLS_INT;
    end else if (flags.all_real) begin
      word_cls = CLS_REAL;
    end else if (flags.saw_quote) begin
      word_cls = CLS_STRING;
    end else begin
      word_cls = CLS_IDENT;
    end
    for (int k = NUM_FIXED - 1; k >= 0; k--) begin
      if (hit[k]) begin
        word_cls = FIXED_WORDS[k].cls;
      end
    end
  end

endmodule

### sv/word_token_classifier.sv
// Word token classifier.
// in_chan carries source text one byte (ch) per transfer, src_last flagging
// the final byte. out_chan carries one token class per word; run_last marks
// the last token that a given byte produced (a byte yields zero, one or two).
// A transferred byte sits in the input register, is classified against the
// word buffer and pushed into a three-entry result queue once the queue has
// room for all its tokens; its first token is presented from then on.
// Throughput: one byte per cycle while the queue has room for its tokens, set
// by the single classify stage between the input register and the result
// queue. The queue drains one token per cycle while the receiver is ready;
// a byte that produces two tokens waits while fewer than two entries are free.
// A space closes a word; a '$' opening a word, or the last byte, emits the
// end token, after which all input is consumed and dropped until reset.
// Reset (rst_n low, synchronous) empties the input register and the queue,
// clears the current word and re-arms the block for a new source text.
// When the receiver stalls, the queue fills, the input register holds and
// in_chan.ready drops; nothing is lost.
module word_token_classifier (
  input  logic      clk,
  input  logic      rst_n,
  wtc_in_if.sink    in_chan,
  wtc_out_if.source out_chan
);
  import wtc_pkg::*;

  localparam int QUEUE_DEPTH = 3;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       in_ready;

  // Word state
  logic [7:0]       buf_r [BUF_DEPTH];
  logic [LEN_W-1:0] len_r;
  word_flags_t      flags_r;
  logic             done_r;

  // Result queue
  result_t          q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] space;
  logic [1:0]       need_n, push_n;
  logic             pop;

  // Classify datapath
  logic             is_space, dollar_start, is_digit, int_ok, real_ok;
  logic             has_word, has_end, add_en, clear_en;
  logic [LEN_W-1:0] len_add, cls_len;
  word_flags_t      flags_add, cls_flags;
  logic [7:0]       cls_buf [BUF_DEPTH];
  cls_t             word_cls;
  result_t          res0, res1;

  // Accept a byte when the register is empty or drains this cycle
  assign in_ready      = !s1_valid_r || s1_fire;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_ch_r   <= in_chan.ch;
      s1_last_r <= in_chan.src_last;
    end
  end

  // Decode the byte
  assign is_space     = (s1_ch_r == CH_SPACE);
  assign dollar_start = (s1_ch_r == CH_DOLLAR) && (len_r == '0);
  assign is_digit     = s1_ch_r inside {[CH_ZERO:CH_NINE]};
  assign int_ok       = is_digit || (s1_ch_r == CH_MINUS);
  assign real_ok      = int_ok || (s1_ch_r == CH_DOT);

  // Word state as if the byte were appended
  always_comb begin
    len_add             = (len_r < LEN_W'(BUF_DEPTH)) ? len_r + LEN_W'(1) : LEN_LONG;
    flags_add.all_int   = flags_r.all_int && int_ok;
    flags_add.all_real  = flags_r.all_real && real_ok;
    flags_add.saw_quote = flags_r.saw_quote || (s1_ch_r == CH_QUOTE);
  end

  // A space classifies the gathered word; the last byte classifies it with the byte added
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      cls_buf[i] = (!is_space && (len_r == LEN_W'(i))) ? s1_ch_r : buf_r[i];
    end
    cls_len   = is_space ? len_r : len_add;
    cls_flags = is_space ? flags_r : flags_add;
  end

  wtc_classify u_classify (
    .word_buf (cls_buf),
    .word_len (cls_len),
    .flags    (cls_flags),
    .word_cls (word_cls)
  );

  // Results of this byte
  always_comb begin
    has_word = 1'b0;
    has_end  = 1'b0;
    if (!done_r) begin
      has_word = is_space ? (len_r != '0) : (s1_last_r && !dollar_start);
      has_end  = s1_last_r || dollar_start;
    end
    need_n        = {1'b0, has_word} + {1'b0, has_end};
    res0.cls      = has_word ? word_cls : CLS_END;
    res0.run_last = !(has_word && has_end);
    res1.cls      = CLS_END;
    res1.run_last = 1'b1;
  end

  // Advance the byte only when the queue has room for all its results
  assign space   = CNT_W'(QUEUE_DEPTH) - cnt_r;
  assign s1_fire = s1_valid_r && (CNT_W'(need_n) <= space);
  assign push_n  = s1_fire ? need_n : 2'd0;

  assign add_en   = s1_fire && !done_r && !is_space && !dollar_start && !s1_last_r;
  assign clear_en = s1_fire && !done_r && !add_en;

  // Update word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      flags_r <= FLAGS_CLEAR;
      done_r  <= 1'b0;
    end else begin
      if (add_en) begin
        len_r   <= len_add;
        flags_r <= flags_add;
      end else if (clear_en) begin
        len_r   <= '0;
        flags_r <= FLAGS_CLEAR;
      end
      if (s1_fire && has_end) begin
        done_r <= 1'b1;
      end
    end
  end

  // Store the byte at the current length while the buffer has room
  always_ff @(posedge clk) begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (add_en && (len_r == LEN_W'(i))) begin
        buf_r[i] <= s1_ch_r;
      end
    end
  end

  // Result queue
  assign pop = (cnt_r != '0) && out_chan.ready;

  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_nxt = ptr_inc(wr_ptr_r);
      2'd2:    wr_ptr_nxt = ptr_inc(ptr_inc(wr_ptr_r));
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[ptr_inc(wr_ptr_r)] <= res1;
    end
  end

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.token_class = q_r[rd_ptr_r].cls;
  assign out_chan.run_last    = q_r[rd_ptr_r].run_last;

  // Checks
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |-> ({1'b0, cnt_r} + {1'b0, CNT_W'(push_n)} <= (CNT_W + 1)'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("end of source cleared without reset");

  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (push_n == 2'd0))
    else $error("token produced after end of source");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) && has_end |-> (res0.run_last || (push_n == 2'd2)))
    else $error("end token not last of its byte");

endmodule
